// ===== sv/pwlrgb_pkg.sv =====
// Package: shared widths, constants, register indexes and stage types for the window/level mapper.
`timescale 1ns / 1ps
`default_nettype none

package pwlrgb_pkg;

   // Pixel width used in wide mode (16 to 32).
   localparam int PIXEL_BITS = 32;

   localparam int LEVEL_BITS = 31;
   localparam int VALUE_BITS = 32;
   localparam int QUOT_BITS  = 8;
   localparam int DIV_STEPS  = QUOT_BITS;
   // Span times 255 stays below 2^39.
   localparam int NUM_BITS   = LEVEL_BITS + QUOT_BITS;
   // Front stage, scale stage, one stage per quotient bit, output register.
   localparam int STAGES     = DIV_STEPS + 3;

   localparam logic [VALUE_BITS-1:0] WIDE_MASK =
      VALUE_BITS'((64'd1 << PIXEL_BITS) - 64'd1);
   localparam logic [VALUE_BITS-1:0] NARROW_MASK = VALUE_BITS'(32'h0000_ffff);

   localparam logic [LEVEL_BITS-1:0] WHITE_RESET = LEVEL_BITS'(0);
   localparam logic [LEVEL_BITS-1:0] BLACK_RESET = LEVEL_BITS'(65535);
   localparam logic [LEVEL_BITS-1:0] MIN_SPAN    = LEVEL_BITS'(1);

   localparam logic [7:0] FULL_SCALE = 8'hff;
   localparam logic [7:0] ZERO_SCALE = 8'h00;

   typedef enum logic [1:0] {
      CSR_WHITE = 2'd0,
      CSR_BLACK = 2'd1,
      CSR_DEPTH = 2'd2
   } csr_index_type;

   // After masking and the white compare.
   typedef struct packed {
      logic                  overload;
      logic                  white;
      logic [VALUE_BITS-1:0] diff;
      logic [LEVEL_BITS-1:0] span;
   } front_type;

   // One step of the restoring divider.
   typedef struct packed {
      logic                  overload;
      logic                  white;
      logic                  black;
      logic [LEVEL_BITS-1:0] span;
      logic [NUM_BITS-1:0]   rem;
      logic [QUOT_BITS-1:0]  quot;
   } div_type;

endpackage

`default_nettype wire

// ===== sv/pixel_window_level_to_rgb_top.sv =====
// Top level: window/level mapping of detector pixels to RGB, deep pipeline.
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Direction | Handshake            | Payload
// ---------+-----------+----------------------+------------------------------------
// req_     | in        | req_valid/req_ready  | req_pixel_value[31:0]
// rsp_     | out       | rsp_valid/rsp_ready  | rsp_red, rsp_green, rsp_blue [7:0]
// csr_     | in        | csr_valid/csr_ready  | csr_index[1:0], csr_data[31:0]
//
// One pixel per clock sustained while rsp_ready stays high.
// The pipeline holds one stage per quotient bit (8),
// plus a front stage, a scale stage and the output register (11 registers, the
// front one loaded at the accepting edge).
// Reset (synchronous, active high) empties the pipeline and loads register defaults.
// Each stage loads when it is empty or its successor moves, so bubbles fill
// during an output stall and a stall drops or repeats nothing.
// csr_ready is always high; writes take effect on the next clock.

module pixel_window_level_to_rgb_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [31:0] req_pixel_value,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_red,
   output logic [7:0]       rsp_green,
   output logic [7:0]       rsp_blue,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_data
);

   // Configuration registers.
   logic [pwlrgb_pkg::LEVEL_BITS-1:0] white_ff;
   logic [pwlrgb_pkg::LEVEL_BITS-1:0] black_ff;
   logic                              depth_ff;

   // Pipeline valid bits and per-stage advance.
   logic vld_ff [0:pwlrgb_pkg::STAGES-1];
   logic vld_in [0:pwlrgb_pkg::STAGES-1];
   logic stage_ready [0:pwlrgb_pkg::STAGES-1];

   // Payload registers.
   pwlrgb_pkg::front_type front_ff;
   pwlrgb_pkg::front_type front_in;
   pwlrgb_pkg::div_type   div_ff [0:pwlrgb_pkg::DIV_STEPS];
   pwlrgb_pkg::div_type   div_in [0:pwlrgb_pkg::DIV_STEPS];
   logic [7:0] red_ff;
   logic [7:0] red_in;
   logic [7:0] green_ff;
   logic [7:0] green_in;
   logic [7:0] blue_ff;
   logic [7:0] blue_in;

   logic [pwlrgb_pkg::VALUE_BITS-1:0] pix_mask;
   logic [pwlrgb_pkg::VALUE_BITS-1:0] pix_used;
   logic [pwlrgb_pkg::QUOT_BITS-1:0]  quot_up;
   logic [7:0]                        grey;

   // ---------------------------------------------------------------------
   // Configuration port: always ready, out-of-range indexes drop the write.
   // ---------------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         white_ff <= pwlrgb_pkg::WHITE_RESET;
         black_ff <= pwlrgb_pkg::BLACK_RESET;
         depth_ff <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            pwlrgb_pkg::CSR_WHITE: begin
               white_ff <= csr_data[pwlrgb_pkg::LEVEL_BITS-1:0];
            end
            pwlrgb_pkg::CSR_BLACK: begin
               black_ff <= csr_data[pwlrgb_pkg::LEVEL_BITS-1:0];
            end
            pwlrgb_pkg::CSR_DEPTH: begin
               depth_ff <= csr_data[0];
            end
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Flow control: a stage advances when it is empty or its successor does.
   // ---------------------------------------------------------------------
   always_comb begin
      stage_ready[pwlrgb_pkg::STAGES-1] = !vld_ff[pwlrgb_pkg::STAGES-1] || rsp_ready;
      for (int i = pwlrgb_pkg::STAGES - 2; i >= 0; i--) begin
         stage_ready[i] = !vld_ff[i] || stage_ready[i+1];
      end
      vld_in[0] = stage_ready[0] ? req_valid : vld_ff[0];
      for (int i = 1; i < pwlrgb_pkg::STAGES; i++) begin
         vld_in[i] = stage_ready[i] ? vld_ff[i-1] : vld_ff[i];
      end
   end

   assign req_ready = stage_ready[0];
   assign rsp_valid = vld_ff[pwlrgb_pkg::STAGES-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < pwlrgb_pkg::STAGES; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else begin
         for (int i = 0; i < pwlrgb_pkg::STAGES; i++) begin
            vld_ff[i] <= vld_in[i];
         end
      end
   end

   // ---------------------------------------------------------------------
   // Front stage: mask to the pixel depth, flag overload, compare with white,
   // and form the ramp span. A black level at or below white gives span 1,
   // which is the same as taking black as white + 1.
   // ---------------------------------------------------------------------
   always_comb begin
      pix_mask = depth_ff ? pwlrgb_pkg::WIDE_MASK : pwlrgb_pkg::NARROW_MASK;
      pix_used = req_pixel_value & pix_mask;
      front_in.overload = (pix_used == pix_mask);
      front_in.white    = (pix_used <= {1'b0, white_ff});
      front_in.diff     = pix_used - {1'b0, white_ff};
      front_in.span     = (black_ff > white_ff) ? (black_ff - white_ff)
                                                : pwlrgb_pkg::MIN_SPAN;
   end

   // ---------------------------------------------------------------------
   // Scale stage: black when v - w reaches the span; otherwise the numerator
   // (v - w) * 255 as a shift and subtract. Below the span, v - w fits in
   // 31 bits, so the upper bit of the difference is dropped.
   // ---------------------------------------------------------------------
   always_comb begin
      div_in[0].overload = front_ff.overload;
      div_in[0].white    = front_ff.white;
      div_in[0].black    = (front_ff.diff >= {1'b0, front_ff.span});
      div_in[0].span     = front_ff.span;
      div_in[0].rem      = {front_ff.diff[pwlrgb_pkg::LEVEL_BITS-1:0],
                            {pwlrgb_pkg::QUOT_BITS{1'b0}}}
                         - {{pwlrgb_pkg::QUOT_BITS{1'b0}},
                            front_ff.diff[pwlrgb_pkg::LEVEL_BITS-1:0]};
      div_in[0].quot     = '0;
   end

   // ---------------------------------------------------------------------
   // Restoring divider, one quotient bit per stage, most significant first.
   // The numerator is below 255 * span, so eight bits hold the quotient.
   // ---------------------------------------------------------------------
   always_comb begin
      for (int j = 0; j < pwlrgb_pkg::DIV_STEPS; j++) begin
         logic [pwlrgb_pkg::NUM_BITS-1:0] span_sh;
         span_sh = {{pwlrgb_pkg::QUOT_BITS{1'b0}}, div_ff[j].span}
                   << (pwlrgb_pkg::DIV_STEPS - 1 - j);
         div_in[j+1] = div_ff[j];
         if (div_ff[j].rem >= span_sh) begin
            div_in[j+1].rem = div_ff[j].rem - span_sh;
            div_in[j+1].quot[pwlrgb_pkg::DIV_STEPS-1-j] = 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Output stage: round the quotient up on a nonzero remainder, invert to a grey
   // level (full scale for white, zero for black), and select red for overload.
   // ---------------------------------------------------------------------
   always_comb begin
      quot_up = div_ff[pwlrgb_pkg::DIV_STEPS].quot
              + {{(pwlrgb_pkg::QUOT_BITS-1){1'b0}},
                 (div_ff[pwlrgb_pkg::DIV_STEPS].rem != '0)};
      if (div_ff[pwlrgb_pkg::DIV_STEPS].white) begin
         grey = pwlrgb_pkg::FULL_SCALE;
      end else if (div_ff[pwlrgb_pkg::DIV_STEPS].black) begin
         grey = pwlrgb_pkg::ZERO_SCALE;
      end else begin
         grey = pwlrgb_pkg::FULL_SCALE - quot_up;
      end
      if (div_ff[pwlrgb_pkg::DIV_STEPS].overload) begin
         red_in   = pwlrgb_pkg::FULL_SCALE;
         green_in = pwlrgb_pkg::ZERO_SCALE;
         blue_in  = pwlrgb_pkg::ZERO_SCALE;
      end else begin
         red_in   = grey;
         green_in = grey;
         blue_in  = grey;
      end
   end

   // Payload registers: load only when the stage advances and data arrives.
   always_ff @(posedge clock) begin
      if (stage_ready[0] && req_valid) begin
         front_ff <= front_in;
      end
      for (int k = 0; k <= pwlrgb_pkg::DIV_STEPS; k++) begin
         if (stage_ready[k+1] && vld_ff[k]) begin
            div_ff[k] <= div_in[k];
         end
      end
      if (stage_ready[pwlrgb_pkg::STAGES-1] && vld_ff[pwlrgb_pkg::STAGES-2]) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign rsp_red   = red_ff;
   assign rsp_green = green_ff;
   assign rsp_blue  = blue_ff;

`ifndef SYNTHESIS
   // Input stalls only when the whole pipeline is full and the output is held.
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> vld_ff[0] && rsp_valid && !rsp_ready)
      else $error("input stalled with room in the pipeline");

   // An accepted transaction lands in the front stage.
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> vld_ff[0])
      else $error("accepted transaction lost at the front stage");

   // The ramp span is never zero.
   a_span_nonzero: assert property (@(posedge clock) disable iff (reset)
      vld_ff[0] |-> front_ff.span != '0)
      else $error("zero ramp span");

   // Inside the ramp the final remainder is below the span.
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      vld_ff[pwlrgb_pkg::STAGES-2] && !div_ff[pwlrgb_pkg::DIV_STEPS].black
      && !div_ff[pwlrgb_pkg::DIV_STEPS].white |->
      div_ff[pwlrgb_pkg::DIV_STEPS].rem
         < {{pwlrgb_pkg::QUOT_BITS{1'b0}}, div_ff[pwlrgb_pkg::DIV_STEPS].span})
      else $error("divider remainder out of range");

   // Results are grey, or pure red for overload.
   a_rgb_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_green == rsp_blue)
         && (rsp_red == rsp_green
             || (rsp_red == pwlrgb_pkg::FULL_SCALE && rsp_green == pwlrgb_pkg::ZERO_SCALE)))
      else $error("result is neither grey nor overload red");
`endif

endmodule

`default_nettype wire

// ===== tb/pixel_window_level_to_rgb_top_test.sv =====
// Self-checking testbench for the window/level pixel to RGB mapper.
`timescale 1ns / 1ps

module pixel_window_level_to_rgb_top_test;

   localparam int CYCLE_LIMIT     = 200000;
   // Pipeline depth is 11; settle time after the drain, before touching registers.
   localparam int DRAIN_CYCLES    = 30;
   localparam int RESET_CYCLES    = 5;
   localparam int DIRECTED_PHASES = 4;
   localparam int RANDOM_PHASES   = 12;
   localparam int TOTAL_PHASES    = DIRECTED_PHASES + RANDOM_PHASES;
   localparam int PIXELS_PER_PHASE = 157;
   // Unused register index: the block must ignore writes to it.
   localparam logic [1:0] CSR_SPARE = 2'd3;
   localparam logic [pwlrgb_pkg::LEVEL_BITS-1:0] LEVEL_MAX = '1;

   typedef struct packed {
      logic [31:0] pixel;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
   } rgb_expect_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic [31:0] req_pixel_value = '0;
   logic        rsp_ready = 1'b0;
   logic        csr_valid = 1'b0;
   logic [1:0]  csr_index = pwlrgb_pkg::CSR_WHITE;
   logic [31:0] csr_data = '0;
   logic        req_ready;
   logic        rsp_valid;
   logic [7:0]  rsp_red;
   logic [7:0]  rsp_green;
   logic [7:0]  rsp_blue;
   logic        csr_ready;

   // Shadow copy of the register file, updated on every accepted write.
   logic [pwlrgb_pkg::LEVEL_BITS-1:0] white_cfg = pwlrgb_pkg::WHITE_RESET;
   logic [pwlrgb_pkg::LEVEL_BITS-1:0] black_cfg = pwlrgb_pkg::BLACK_RESET;
   logic                              depth_cfg = 1'b0;

   logic [31:0]    pixel_queue[$];
   rgb_expect_type rgb_expected[$];
   rgb_expect_type rsp_want;
   logic        req_fire = 1'b0;
   int          queued_count = 0;
   int          accepted_count = 0;
   int          error_count = 0;
   int          cycle_count = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;

   pixel_window_level_to_rgb_top i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_pixel_value (req_pixel_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_red         (rsp_red),
      .rsp_green       (rsp_green),
      .rsp_blue        (rsp_blue),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always #10 clock = ~clock;

   // Compute the color of one pixel under the current shadow registers.
   // Work in 64 bits so white+1 and the 255x product never overflow.
   function automatic rgb_expect_type predict_rgb(input logic [31:0] raw);
      rgb_expect_type res;
      logic [63:0] mask, v, w, b, d, num, q;
      logic [7:0]  g;
      mask = depth_cfg ? 64'(pwlrgb_pkg::WIDE_MASK) : 64'(pwlrgb_pkg::NARROW_MASK);
      v = 64'(raw) & mask;
      res.pixel = raw;
      if (v == mask) begin
         // Overload: every used bit set gives pure red.
         res.red   = pwlrgb_pkg::FULL_SCALE;
         res.green = pwlrgb_pkg::ZERO_SCALE;
         res.blue  = pwlrgb_pkg::ZERO_SCALE;
      end else begin
         w = 64'(white_cfg);
         b = 64'(black_cfg);
         // Raise black above white so the ramp span is never zero.
         if (b <= w) b = w + 64'd1;
         if (v <= w) begin
            g = pwlrgb_pkg::FULL_SCALE;
         end else if (v >= b) begin
            g = pwlrgb_pkg::ZERO_SCALE;
         end else begin
            d   = b - w;
            num = (v - w) * 64'd255;
            q   = num / d;
            // Round the scaled offset up.
            if (q * d != num) q = q + 64'd1;
            if (q > 64'd255) q = 64'd255;
            g = 8'(64'd255 - q);
         end
         res.red   = g;
         res.green = g;
         res.blue  = g;
      end
      return res;
   endfunction

   // Pick a pixel aimed at the window edges, the ramp, overload or anything.
   function automatic logic [31:0] random_pixel();
      logic [63:0] w, b, span, off;
      logic [31:0] hi, p;
      w = 64'(white_cfg);
      b = 64'(black_cfg);
      if (b <= w) b = w + 64'd1;
      span = b - w;
      // Narrow mode ignores the upper half: fill it with junk.
      hi = depth_cfg ? 32'h0 : ($urandom & 32'hffff_0000);
      case ($urandom_range(9))
         0: p = $urandom;
         1: p = (depth_cfg ? pwlrgb_pkg::WIDE_MASK : pwlrgb_pkg::NARROW_MASK) | hi;
         2: p = 32'(w + 64'($urandom_range(6)) - 64'd3) | hi;
         3: p = 32'(b + 64'($urandom_range(6)) - 64'd3) | hi;
         default: begin
            off = {$urandom, $urandom} % span;
            p = 32'(w + off) | hi;
         end
      endcase
      return p;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("ERROR %0t: %s: got %0h, expected %0h", $time, what, got, want);
      error_count++;
   endtask

   task automatic queue_pixel(input logic [31:0] pix);
      pixel_queue.push_back(pix);
      queued_count++;
   endtask

   // Write one register; valid stays high so back-to-back writes need no gap.
   task automatic write_csr(input logic [1:0] idx, input logic [31:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         pwlrgb_pkg::CSR_WHITE: white_cfg = data[pwlrgb_pkg::LEVEL_BITS-1:0];
         pwlrgb_pkg::CSR_BLACK: black_cfg = data[pwlrgb_pkg::LEVEL_BITS-1:0];
         pwlrgb_pkg::CSR_DEPTH: depth_cfg = data[0];
         default: ;
      endcase
   endtask

   // Load all three registers plus a junk write to the spare index.
   // Set the bits above each register's width at random to check they drop.
   task automatic configure(input logic [pwlrgb_pkg::LEVEL_BITS-1:0] w,
                            input logic [pwlrgb_pkg::LEVEL_BITS-1:0] b,
                            input logic d);
      write_csr(pwlrgb_pkg::CSR_WHITE, {1'($urandom), w});
      write_csr(pwlrgb_pkg::CSR_BLACK, {1'($urandom), b});
      write_csr(CSR_SPARE, $urandom);
      write_csr(pwlrgb_pkg::CSR_DEPTH, ($urandom & 32'hffff_fffe) | 32'(d));
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Wait for every queued pixel to come back, then let the pipeline settle.
   task automatic drain();
      while (accepted_count != queued_count || rgb_expected.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Thirds of the run: mostly receiver stalls, then mostly sender gaps, then none.
   task automatic set_idling(input int phase);
      case (phase * 3 / TOTAL_PHASES)
         0: begin
            send_idle_pct = 8;
            recv_idle_pct = 53;
         end
         1: begin
            send_idle_pct = 53;
            recv_idle_pct = 8;
         end
         default: begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
      endcase
   endtask

   // Driver: present the next pixel once the previous transaction is taken.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (pixel_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid       <= 1'b1;
            req_pixel_value <= pixel_queue.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver back-pressure.
   always @(negedge clock) begin
      rsp_ready <= !reset && ($urandom_range(99) >= recv_idle_pct);
   end

   // Monitor: check the response side first, then record the new request.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (rgb_expected.size() == 0) begin
            report_mismatch("response with nothing outstanding",
                            {8'h0, rsp_red, rsp_green, rsp_blue}, 32'h0);
         end else begin
            rsp_want = rgb_expected.pop_front();
            if (rsp_red !== rsp_want.red)
               report_mismatch($sformatf("red of pixel %08h", rsp_want.pixel),
                               32'(rsp_red), 32'(rsp_want.red));
            if (rsp_green !== rsp_want.green)
               report_mismatch($sformatf("green of pixel %08h", rsp_want.pixel),
                               32'(rsp_green), 32'(rsp_want.green));
            if (rsp_blue !== rsp_want.blue)
               report_mismatch($sformatf("blue of pixel %08h", rsp_want.pixel),
                               32'(rsp_blue), 32'(rsp_want.blue));
         end
      end
      req_fire <= !reset && req_valid && req_ready;
      if (!reset && req_valid && req_ready) begin
         rgb_expected.push_back(predict_rgb(req_pixel_value));
         accepted_count++;
      end
   end

   // Watchdog: end the run if it never drains.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      logic [pwlrgb_pkg::LEVEL_BITS-1:0] w_new, b_new;
      logic                              d_new;
      int                                phase, n;

      // Hold reset for the first cycles, release on a falling edge.
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      // Reset defaults: narrow mode, white 0, black 65535.
      // Cover white, ramp ends, overload and ignored upper bits.
      set_idling(0);
      queue_pixel(32'h0000_0000);
      queue_pixel(32'h0000_0001);
      queue_pixel(32'h0000_8000);
      queue_pixel(32'h0000_fffe);
      queue_pixel(32'h0000_ffff);
      queue_pixel(32'h1234_ffff);
      queue_pixel(32'hffff_0000);
      queue_pixel(32'hffff_ffff);
      drain();

      // Black below white in wide mode: effective black becomes white+1.
      set_idling(1);
      configure(pwlrgb_pkg::LEVEL_BITS'(100), pwlrgb_pkg::LEVEL_BITS'(50), 1'b1);
      queue_pixel(32'd99);
      queue_pixel(32'd100);
      queue_pixel(32'd101);
      queue_pixel(32'h0000_ffff);
      queue_pixel(32'hffff_fffe);
      queue_pixel(32'hffff_ffff);
      drain();

      // Both levels at their maximum: white+1 must not wrap.
      set_idling(2);
      configure(LEVEL_MAX, LEVEL_MAX, 1'b1);
      queue_pixel(32'h7fff_ffff);
      queue_pixel(32'h8000_0000);
      queue_pixel(32'hffff_fffe);
      drain();

      // Widest possible ramp: check rounding at both ends.
      set_idling(3);
      configure('0, LEVEL_MAX, 1'b1);
      queue_pixel(32'h0000_0001);
      queue_pixel(32'h3fff_ffff);
      queue_pixel(32'h7fff_fffe);
      queue_pixel(32'h7fff_ffff);
      drain();

      // Random phases: a fresh register setting, then a batch of pixels.
      for (phase = DIRECTED_PHASES; phase < TOTAL_PHASES; phase++) begin
         set_idling(phase);
         case ($urandom_range(7))
            1: begin
               w_new = pwlrgb_pkg::LEVEL_BITS'($urandom);
               b_new = pwlrgb_pkg::LEVEL_BITS'($urandom);
               d_new = 1'b1;
            end
            2: begin
               w_new = pwlrgb_pkg::LEVEL_BITS'($urandom);
               b_new = w_new + pwlrgb_pkg::LEVEL_BITS'($urandom_range(1, 3));
               d_new = 1'($urandom);
            end
            3: begin
               w_new = pwlrgb_pkg::LEVEL_BITS'($urandom);
               b_new = pwlrgb_pkg::LEVEL_BITS'($urandom % (32'(w_new) + 32'd1));
               d_new = 1'($urandom);
            end
            4: begin
               w_new = $urandom_range(1) ? LEVEL_MAX : '0;
               b_new = $urandom_range(1) ? LEVEL_MAX : '0;
               d_new = 1'($urandom);
            end
            5: begin
               w_new = pwlrgb_pkg::LEVEL_BITS'($urandom_range(1000));
               b_new = LEVEL_MAX - pwlrgb_pkg::LEVEL_BITS'($urandom_range(1000));
               d_new = 1'b1;
            end
            default: begin
               // Typical 16-bit window.
               w_new = pwlrgb_pkg::LEVEL_BITS'($urandom_range(60000));
               b_new = w_new + pwlrgb_pkg::LEVEL_BITS'($urandom_range(1, 5000));
               d_new = 1'b0;
            end
         endcase
         configure(w_new, b_new, d_new);
         for (n = 0; n < PIXELS_PER_PHASE; n++)
            queue_pixel(random_pixel());
         drain();
      end

      if (rgb_expected.size() != 0)
         report_mismatch("responses still outstanding", 32'(rgb_expected.size()), 32'h0);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== pixel_window_level_to_rgb_top.f =====
sv/pwlrgb_pkg.sv
sv/pixel_window_level_to_rgb_top.sv
tb/pixel_window_level_to_rgb_top_test.sv
